// ===== rtl/core/pea_pkg.sv =====
// Shared types, constants and helpers for the pair energy accumulator.
package pea_pkg;

   localparam int ENERGY_FRAC_BITS = 32;
   localparam int EXP_W            = 12;
   localparam int PC_W             = 5;

   // Configuration register indexes
   localparam logic [1:0] CSR_BOX_X          = 2'd0;
   localparam logic [1:0] CSR_BOX_Y          = 2'd1;
   localparam logic [1:0] CSR_BOX_Z          = 2'd2;
   localparam logic [1:0] CSR_COULOMB_FACTOR = 2'd3;

   localparam logic [31:0] COULOMB_FACTOR_RESET = 32'd1165521633;

   // Unsigned float: normalized 64-bit mantissa (or zero) and binary exponent
   typedef struct packed {
      logic [63:0]             m;
      logic signed [EXP_W-1:0] e;
   } fl_type;

   // Work handed from the front to the back
   typedef struct packed {
      logic [63:0] dist_sq;
      logic [39:0] repulsion_coef;
      logic [39:0] dispersion_coef;
      logic [31:0] first_charge;
      logic [31:0] second_charge;
      logic        pair_last;
   } job_type;

   typedef enum logic [2:0] {
      OP_FROM, OP_MUL, OP_DIV, OP_SQRT, OP_FIX, OP_ACC
   } op_type;

   // Back-end program steps
   localparam logic [PC_W-1:0] PC_NORM_S   = 5'd0;
   localparam logic [PC_W-1:0] PC_SQ2      = 5'd1;
   localparam logic [PC_W-1:0] PC_CUBE     = 5'd2;
   localparam logic [PC_W-1:0] PC_SIXTH    = 5'd3;
   localparam logic [PC_W-1:0] PC_NORM_C12 = 5'd4;
   localparam logic [PC_W-1:0] PC_DIV12    = 5'd5;
   localparam logic [PC_W-1:0] PC_FIX12    = 5'd6;
   localparam logic [PC_W-1:0] PC_NORM_C6  = 5'd7;
   localparam logic [PC_W-1:0] PC_DIV6     = 5'd8;
   localparam logic [PC_W-1:0] PC_FIX6     = 5'd9;
   localparam logic [PC_W-1:0] PC_NORM_K   = 5'd10;
   localparam logic [PC_W-1:0] PC_NORM_QI  = 5'd11;
   localparam logic [PC_W-1:0] PC_MUL_QI   = 5'd12;
   localparam logic [PC_W-1:0] PC_NORM_QJ  = 5'd13;
   localparam logic [PC_W-1:0] PC_MUL_QJ   = 5'd14;
   localparam logic [PC_W-1:0] PC_SQRT     = 5'd15;
   localparam logic [PC_W-1:0] PC_NORM_R   = 5'd16;
   localparam logic [PC_W-1:0] PC_DIVC     = 5'd17;
   localparam logic [PC_W-1:0] PC_FIXC     = 5'd18;
   localparam logic [PC_W-1:0] PC_ACC      = 5'd19;

   // Scale exponents applied when a term is turned into an integer
   localparam logic signed [EXP_W-1:0] SHIFT_T12 = EXP_W'(248 + ENERGY_FRAC_BITS);
   localparam logic signed [EXP_W-1:0] SHIFT_T6  = EXP_W'(104 + ENERGY_FRAC_BITS);
   localparam logic signed [EXP_W-1:0] SHIFT_TC  = EXP_W'(ENERGY_FRAC_BITS - 55);
   localparam logic signed [EXP_W-1:0] FIX_FLOOR = EXP_W'(-64);

   function automatic op_type op_of(logic [PC_W-1:0] pc);
      op_type r;
      case (pc) inside
         PC_NORM_S, PC_NORM_C12, PC_NORM_C6, PC_NORM_K,
         PC_NORM_QI, PC_NORM_QJ, PC_NORM_R:           r = OP_FROM;
         PC_SQ2, PC_CUBE, PC_SIXTH, PC_MUL_QI, PC_MUL_QJ: r = OP_MUL;
         PC_DIV12, PC_DIV6, PC_DIVC:                  r = OP_DIV;
         PC_SQRT:                                     r = OP_SQRT;
         PC_FIX12, PC_FIX6, PC_FIXC:                  r = OP_FIX;
         default:                                     r = OP_ACC;
      endcase
      return r;
   endfunction

   // One stage of a six-stage leading-zero normalize (32,16,8,4,2,1)
   function automatic fl_type norm_step(fl_type a, logic [2:0] k);
      fl_type r;
      r = a;
      case (k)
         3'd0: if (a.m[63:32] == '0) begin
            r.m = {a.m[31:0], 32'd0};
            r.e = a.e - EXP_W'(32);
         end
         3'd1: if (a.m[63:48] == '0) begin
            r.m = {a.m[47:0], 16'd0};
            r.e = a.e - EXP_W'(16);
         end
         3'd2: if (a.m[63:56] == '0) begin
            r.m = {a.m[55:0], 8'd0};
            r.e = a.e - EXP_W'(8);
         end
         3'd3: if (a.m[63:60] == '0) begin
            r.m = {a.m[59:0], 4'd0};
            r.e = a.e - EXP_W'(4);
         end
         3'd4: if (a.m[63:62] == '0) begin
            r.m = {a.m[61:0], 2'd0};
            r.e = a.e - EXP_W'(2);
         end
         3'd5: if (!a.m[63]) begin
            r.m = {a.m[62:0], 1'b0};
            r.e = a.e - EXP_W'(1);
         end
         default: r = a;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/pea_front.sv =====
// Front end: takes a pair, forms minimum-image displacements and the squared distance.
module pea_front
   import pea_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [335:0] req_tdata,
   input  logic         req_tlast,
   input  logic [30:0]  box_x,
   input  logic [30:0]  box_y,
   input  logic [30:0]  box_z,
   output logic         push_valid,
   input  logic         push_ready,
   output job_type      push_job
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_CALC = 3'b010,
      F_PUSH = 3'b100
   } fst_type;

   fst_type     state_ff, state_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [31:0] pa_ff [3];
   logic [31:0] pa_in [3];
   logic [31:0] pb_ff [3];
   logic [31:0] pb_in [3];
   job_type     job_ff, job_in;
   logic [61:0] sq_ff, sq_in;
   logic [63:0] sum_ff, sum_in;

   logic [31:0]        p_sel, q_sel;
   logic [30:0]        box_sel;
   logic signed [34:0] d, d2, bs, absd;
   logic [30:0]        mag;

   // Displacement of the axis picked by the counter
   always_comb begin
      p_sel   = pa_ff[0];
      q_sel   = pb_ff[0];
      box_sel = box_x;
      case (cnt_ff)
         2'd1: begin
            p_sel   = pa_ff[1];
            q_sel   = pb_ff[1];
            box_sel = box_y;
         end
         2'd2: begin
            p_sel   = pa_ff[2];
            q_sel   = pb_ff[2];
            box_sel = box_z;
         end
         default: begin
            p_sel   = pa_ff[0];
            q_sel   = pb_ff[0];
            box_sel = box_x;
         end
      endcase
      d  = {{3{p_sel[31]}}, p_sel} - {{3{q_sel[31]}}, q_sel};
      bs = {4'd0, box_sel};
      d2 = {d[33:0], 1'b0};
      if (d2 > bs) begin
         d = d - bs;
      end else if (d2 < -bs) begin
         d = d + bs;
      end
      absd = d[34] ? -d : d;
      mag  = (absd > 35'sh7FFFFFFF) ? 31'h7FFFFFFF : absd[30:0];
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      pa_in      = pa_ff;
      pb_in      = pb_ff;
      job_in     = job_ff;
      sq_in      = sq_ff;
      sum_in     = sum_ff;
      req_tready = (state_ff == F_IDLE);
      push_valid = (state_ff == F_PUSH);
      push_job   = job_ff;
      push_job.dist_sq = sum_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_tvalid) begin
               pa_in[0] = req_tdata[31:0];
               pa_in[1] = req_tdata[63:32];
               pa_in[2] = req_tdata[95:64];
               pb_in[0] = req_tdata[127:96];
               pb_in[1] = req_tdata[159:128];
               pb_in[2] = req_tdata[191:160];
               job_in.dist_sq         = '0;
               job_in.repulsion_coef  = req_tdata[231:192];
               job_in.dispersion_coef = req_tdata[271:232];
               job_in.first_charge    = req_tdata[303:272];
               job_in.second_charge   = req_tdata[335:304];
               job_in.pair_last       = req_tlast;
               sum_in   = '0;
               cnt_in   = '0;
               state_in = F_CALC;
            end
         end
         F_CALC: begin
            // square one axis per cycle, add it in the next
            if (cnt_ff != 2'd3) begin
               sq_in = mag * mag;
            end
            if (cnt_ff != 2'd0) begin
               sum_in = sum_ff + {2'd0, sq_ff};
            end
            if (cnt_ff == 2'd3) begin
               state_in = F_PUSH;
            end else begin
               cnt_in = cnt_ff + 2'd1;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      pa_ff  <= pa_in;
      pb_ff  <= pb_in;
      job_ff <= job_in;
      sq_ff  <= sq_in;
      sum_ff <= sum_in;
   end

endmodule

// ===== rtl/core/pea_queue.sv =====
// Two-entry job queue between the front and the back.
module pea_queue
   import pea_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   job_type    ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   always_comb begin
      push_ready = (count_ff != 2'd2);
      pop_valid  = (count_ff != 2'd0);
      pop_job    = ent_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;
      wr_ptr_in  = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in   = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         ent_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/pea_back.sv =====
// Back end: float sequencer (normalize, multiply, divide, root), sums and result register.
module pea_back
   import pea_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  job_type     pop_job,
   input  logic [31:0] coulomb_factor,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] vdw_energy,
   output logic [63:0] coulomb_energy,
   output logic        range_error
);

   typedef enum logic [6:0] {
      B_IDLE = 7'b0000001,
      B_LOAD = 7'b0000010,
      B_NORM = 7'b0000100,
      B_MUL  = 7'b0001000,
      B_DIV  = 7'b0010000,
      B_SQRT = 7'b0100000,
      B_OUT  = 7'b1000000
   } bst_type;

   // B_ACC folded into B_LOAD's accumulate step
   bst_type           state_ff, state_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   job_type           job_ff, job_in;
   fl_type            sf_ff, sf_in, t_ff, t_in, u_ff, u_in;
   fl_type            s3_ff, s3_in, s6_ff, s6_in;
   fl_type            opa_ff, opa_in, opb_ff, opb_in;
   logic [63:0]       wm_ff, wm_in;
   logic signed [EXP_W-1:0] we_ff, we_in;
   logic [6:0]        cnt_ff, cnt_in;
   logic [127:0]      acc_ff, acc_in;
   logic [63:0]       pp_ff, pp_in;
   logic [63:0]       rem_ff, rem_in;
   logic [63:0]       sv_ff, sv_in, sres_ff, sres_in, sone_ff, sone_in;
   logic [31:0]       root_ff, root_in;
   logic [62:0]       t12_ff, t12_in, t6_ff, t6_in, tc_ff, tc_in;
   logic [63:0]       vdw_ff, vdw_in, coul_ff, coul_in;
   logic              err_ff, err_in;
   logic              ov_ff, ov_in;
   logic [63:0]       ovdw_ff, ovdw_in, ocoul_ff, ocoul_in;
   logic              oerr_ff, oerr_in;

   logic              wb_en;
   fl_type            wb_val, sel_a, sel_b, nrm;
   logic [63:0]       from_src, r2, trial;
   logic [31:0]       abs_qi, abs_qj, a_part, b_part;
   logic              extra;
   logic signed [EXP_W-1:0] fix_shift, fix_s, fix_neg;
   logic [63:0]       fix_val;
   logic [63:0]       vterm, cterm;
   logic [64:0]       vsum, csum;

   assign rsp_tvalid     = ov_ff;
   assign vdw_energy     = ovdw_ff;
   assign coulomb_energy = ocoul_ff;
   assign range_error    = oerr_ff;
   assign pop_ready      = (state_ff == B_IDLE);

   // Operand and source selection by program step
   always_comb begin
      abs_qi = job_ff.first_charge[31] ? (~job_ff.first_charge + 32'd1)
                                        : job_ff.first_charge;
      abs_qj = job_ff.second_charge[31] ? (~job_ff.second_charge + 32'd1)
                                         : job_ff.second_charge;
      case (pc_ff)
         PC_NORM_S:   from_src = job_ff.dist_sq;
         PC_NORM_C12: from_src = {24'd0, job_ff.repulsion_coef};
         PC_NORM_C6:  from_src = {24'd0, job_ff.dispersion_coef};
         PC_NORM_K:   from_src = {32'd0, coulomb_factor};
         PC_NORM_QI:  from_src = {32'd0, abs_qi};
         PC_NORM_QJ:  from_src = {32'd0, abs_qj};
         PC_NORM_R:   from_src = {32'd0, root_ff};
         default:     from_src = '0;
      endcase
      case (pc_ff)
         PC_SQ2: begin
            sel_a = sf_ff;
            sel_b = sf_ff;
         end
         PC_CUBE: begin
            sel_a = t_ff;
            sel_b = sf_ff;
         end
         PC_SIXTH: begin
            sel_a = s3_ff;
            sel_b = s3_ff;
         end
         PC_DIV12: begin
            sel_a = t_ff;
            sel_b = s6_ff;
         end
         PC_DIV6: begin
            sel_a = t_ff;
            sel_b = s3_ff;
         end
         default: begin
            sel_a = t_ff;
            sel_b = u_ff;
         end
      endcase
      case (pc_ff)
         PC_FIX12: fix_shift = SHIFT_T12;
         PC_FIX6:  fix_shift = SHIFT_T6;
         default:  fix_shift = SHIFT_TC;
      endcase
      // truncate toward zero, clamp at 2^63-1
      fix_s   = t_ff.e + fix_shift;
      fix_neg = -fix_s;
      if (t_ff.m == '0) begin
         fix_val = '0;
      end else if (fix_s >= 0) begin
         fix_val = 64'h7FFF_FFFF_FFFF_FFFF;
      end else if (fix_s <= FIX_FLOOR) begin
         fix_val = '0;
      end else begin
         fix_val = t_ff.m >> fix_neg[5:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      job_in   = job_ff;
      sf_in    = sf_ff;
      t_in     = t_ff;
      u_in     = u_ff;
      s3_in    = s3_ff;
      s6_in    = s6_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      wm_in    = wm_ff;
      we_in    = we_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      pp_in    = pp_ff;
      rem_in   = rem_ff;
      sv_in    = sv_ff;
      sres_in  = sres_ff;
      sone_in  = sone_ff;
      root_in  = root_ff;
      t12_in   = t12_ff;
      t6_in    = t6_ff;
      tc_in    = tc_ff;
      vdw_in   = vdw_ff;
      coul_in  = coul_ff;
      err_in   = err_ff;
      ov_in    = ov_ff;
      ovdw_in  = ovdw_ff;
      ocoul_in = ocoul_ff;
      oerr_in  = oerr_ff;
      wb_en    = 1'b0;
      wb_val   = '0;
      nrm      = norm_step({wm_ff, we_ff}, cnt_ff[2:0]);
      a_part   = '0;
      b_part   = '0;
      extra    = (sel_a.m < sel_b.m);
      r2       = {rem_ff[62:0], 1'b0};
      trial    = sres_ff + sone_ff;
      vterm    = {1'b0, t12_ff} - {1'b0, t6_ff};
      cterm    = (job_ff.first_charge[31] ^ job_ff.second_charge[31])
                 ? (64'd0 - {1'b0, tc_ff}) : {1'b0, tc_ff};
      vsum     = {vdw_ff[63], vdw_ff} + {vterm[63], vterm};
      csum     = {coul_ff[63], coul_ff} + {cterm[63], cterm};

      if (ov_ff && rsp_tready) begin
         ov_in = 1'b0;
      end

      case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               job_in = pop_job;
               pc_in  = PC_NORM_S;
               state_in = B_LOAD;
               if (pop_job.dist_sq == '0) begin
                  // coincident atoms: no contribution, flag it
                  err_in = 1'b1;
                  t12_in = '0;
                  t6_in  = '0;
                  tc_in  = '0;
                  pc_in  = PC_ACC;
               end
            end
         end
         B_LOAD: begin
            case (op_of(pc_ff))
               OP_FROM: begin
                  wm_in    = from_src;
                  we_in    = '0;
                  cnt_in   = '0;
                  state_in = B_NORM;
               end
               OP_MUL: begin
                  opa_in   = sel_a;
                  opb_in   = sel_b;
                  acc_in   = '0;
                  cnt_in   = '0;
                  state_in = B_MUL;
               end
               OP_DIV: begin
                  opb_in = sel_b;
                  if (sel_a.m == '0) begin
                     wb_en = 1'b1;
                     wb_val = '0;
                     pc_in = pc_ff + PC_W'(1);
                  end else begin
                     rem_in   = extra ? sel_a.m : (sel_a.m - sel_b.m);
                     wm_in    = extra ? 64'd0 : 64'd1;
                     cnt_in   = extra ? 7'd64 : 7'd63;
                     we_in    = sel_a.e - sel_b.e - EXP_W'(63)
                                - {{(EXP_W-1){1'b0}}, extra};
                     state_in = B_DIV;
                  end
               end
               OP_SQRT: begin
                  sv_in    = job_ff.dist_sq;
                  sres_in  = '0;
                  sone_in  = 64'h4000_0000_0000_0000;
                  cnt_in   = '0;
                  state_in = B_SQRT;
               end
               OP_FIX: begin
                  if (t_ff.m != '0 && fix_s >= 0) begin
                     err_in = 1'b1;
                  end
                  case (pc_ff)
                     PC_FIX12: t12_in = fix_val[62:0];
                     PC_FIX6:  t6_in  = fix_val[62:0];
                     default:  tc_in  = fix_val[62:0];
                  endcase
                  pc_in = pc_ff + PC_W'(1);
               end
               default: begin
                  // accumulate with saturation
                  if (vsum[64] != vsum[63]) begin
                     err_in = 1'b1;
                     vdw_in = vsum[64] ? 64'h8000_0000_0000_0000
                                       : 64'h7FFF_FFFF_FFFF_FFFF;
                  end else begin
                     vdw_in = vsum[63:0];
                  end
                  if (csum[64] != csum[63]) begin
                     err_in  = 1'b1;
                     coul_in = csum[64] ? 64'h8000_0000_0000_0000
                                        : 64'h7FFF_FFFF_FFFF_FFFF;
                  end else begin
                     coul_in = csum[63:0];
                  end
                  state_in = job_ff.pair_last ? B_OUT : B_IDLE;
               end
            endcase
         end
         B_NORM: begin
            wm_in = nrm.m;
            we_in = nrm.e;
            if (cnt_ff == 7'd5) begin
               wb_en    = 1'b1;
               wb_val   = (nrm.m == '0) ? '0 : nrm;
               pc_in    = pc_ff + PC_W'(1);
               state_in = B_LOAD;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         B_MUL: begin
            case (cnt_ff)
               7'd0: begin
                  a_part = opa_ff.m[31:0];
                  b_part = opb_ff.m[31:0];
               end
               7'd1: begin
                  a_part = opa_ff.m[31:0];
                  b_part = opb_ff.m[63:32];
               end
               7'd2: begin
                  a_part = opa_ff.m[63:32];
                  b_part = opb_ff.m[31:0];
               end
               7'd3: begin
                  a_part = opa_ff.m[63:32];
                  b_part = opb_ff.m[63:32];
               end
               default: begin
                  a_part = '0;
                  b_part = '0;
               end
            endcase
            if (cnt_ff < 7'd4) begin
               pp_in = a_part * b_part;
            end
            case (cnt_ff)
               7'd1:       acc_in = acc_ff + {64'd0, pp_ff};
               7'd2, 7'd3: acc_in = acc_ff + {32'd0, pp_ff, 32'd0};
               7'd4:       acc_in = acc_ff + {pp_ff, 64'd0};
               default:    acc_in = acc_ff;
            endcase
            if (cnt_ff == 7'd5) begin
               wb_en = 1'b1;
               if (opa_ff.m == '0 || opb_ff.m == '0) begin
                  wb_val = '0;
               end else if (acc_ff[127]) begin
                  wb_val.m = acc_ff[127:64];
                  wb_val.e = opa_ff.e + opb_ff.e + EXP_W'(64);
               end else begin
                  wb_val.m = acc_ff[126:63];
                  wb_val.e = opa_ff.e + opb_ff.e + EXP_W'(63);
               end
               pc_in    = pc_ff + PC_W'(1);
               state_in = B_LOAD;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         B_DIV: begin
            // restoring division, one quotient bit a cycle
            if (cnt_ff != '0) begin
               if (rem_ff[63] || r2 >= opb_ff.m) begin
                  rem_in = r2 - opb_ff.m;
                  wm_in  = {wm_ff[62:0], 1'b1};
               end else begin
                  rem_in = r2;
                  wm_in  = {wm_ff[62:0], 1'b0};
               end
               cnt_in = cnt_ff - 7'd1;
            end else begin
               wb_en    = 1'b1;
               wb_val   = {wm_ff, we_ff};
               pc_in    = pc_ff + PC_W'(1);
               state_in = B_LOAD;
            end
         end
         B_SQRT: begin
            // bit-pair integer root, 32 iterations
            if (sv_ff >= trial) begin
               sv_in   = sv_ff - trial;
               sres_in = (sres_ff >> 1) + sone_ff;
            end else begin
               sres_in = sres_ff >> 1;
            end
            sone_in = sone_ff >> 2;
            if (cnt_ff == 7'd31) begin
               root_in  = sres_in[31:0];
               pc_in    = pc_ff + PC_W'(1);
               state_in = B_LOAD;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         B_OUT: begin
            if (!ov_ff || rsp_tready) begin
               ov_in    = 1'b1;
               ovdw_in  = vdw_ff;
               ocoul_in = coul_ff;
               oerr_in  = err_ff;
               vdw_in   = '0;
               coul_in  = '0;
               err_in   = 1'b0;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase

      if (wb_en) begin
         case (pc_ff)
            PC_NORM_S:                      sf_in = wb_val;
            PC_SIXTH:                       s6_in = wb_val;
            PC_CUBE:                        s3_in = wb_val;
            PC_NORM_QI, PC_NORM_QJ, PC_NORM_R: u_in = wb_val;
            default:                        t_in  = wb_val;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         pc_ff    <= '0;
         cnt_ff   <= '0;
         vdw_ff   <= '0;
         coul_ff  <= '0;
         err_ff   <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         cnt_ff   <= cnt_in;
         vdw_ff   <= vdw_in;
         coul_ff  <= coul_in;
         err_ff   <= err_in;
         ov_ff    <= ov_in;
      end
      job_ff   <= job_in;
      sf_ff    <= sf_in;
      t_ff     <= t_in;
      u_ff     <= u_in;
      s3_ff    <= s3_in;
      s6_ff    <= s6_in;
      opa_ff   <= opa_in;
      opb_ff   <= opb_in;
      wm_ff    <= wm_in;
      we_ff    <= we_in;
      acc_ff   <= acc_in;
      pp_ff    <= pp_in;
      rem_ff   <= rem_in;
      sv_ff    <= sv_in;
      sres_ff  <= sres_in;
      sone_ff  <= sone_in;
      root_ff  <= root_in;
      t12_ff   <= t12_in;
      t6_ff    <= t6_in;
      tc_ff    <= tc_in;
      ovdw_ff  <= ovdw_in;
      ocoul_ff <= ocoul_in;
      oerr_ff  <= oerr_in;
   end

endmodule

// ===== rtl/core/pair_energy_accumulator.sv =====
// Top level of the Lennard-Jones plus Coulomb pair energy accumulator.
//
//   group  dir  payload                                       handshake
//   req_   in   tdata: positions, c12, c6, charges; tlast     tvalid/tready
//   rsp_   out  tdata: vdw, coulomb energies; tuser: error    tvalid/tready
//   csr_   in   box_x, box_y, box_z, coulomb_factor           csr_we only
//
// Front takes a word (accept, 3 squares, final add, push), queues it, then takes the next.
// Back works a pair through normalizes, multiplies, three one-bit-a-cycle divisions and the
// integer root, then sums; a last pair then loads the result, a coincident pair only sums.
// Reset (synchronous, high) clears the sums, error flag, queue and handshakes
// and loads the reset register values. Front and back stall independently
// through the two-entry queue; the result register holds until rsp_tready.
module pair_energy_accumulator
   import pea_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z (32b each),
   // repulsion_coef (40b), dispersion_coef (40b), first_charge, second_charge
   input  logic [335:0] req_tdata,
   input  logic         req_tlast,       // pair_last
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // vdw_energy (64b), coulomb_energy (64b)
   output logic [127:0] rsp_tdata,
   output logic [0:0]   rsp_tuser,       // range_error
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);

   logic [30:0] box_x_ff, box_x_in, box_y_ff, box_y_in, box_z_ff, box_z_in;
   logic [31:0] cf_ff, cf_in;

   logic        push_valid, push_ready, pop_valid, pop_ready;
   job_type     push_job, pop_job;
   logic [63:0] vdw_energy, coulomb_energy;
   logic        range_error;

   // Configuration registers
   always_comb begin
      box_x_in = box_x_ff;
      box_y_in = box_y_ff;
      box_z_in = box_z_ff;
      cf_in    = cf_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_BOX_X:          box_x_in = csr_wdata[30:0];
            CSR_BOX_Y:          box_y_in = csr_wdata[30:0];
            CSR_BOX_Z:          box_z_in = csr_wdata[30:0];
            CSR_COULOMB_FACTOR: cf_in    = csr_wdata;
            default:            cf_in    = cf_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff <= '0;
         box_y_ff <= '0;
         box_z_ff <= '0;
         cf_ff    <= COULOMB_FACTOR_RESET;
      end else begin
         box_x_ff <= box_x_in;
         box_y_ff <= box_y_in;
         box_z_ff <= box_z_in;
         cf_ff    <= cf_in;
      end
   end

   pea_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .box_x      (box_x_ff),
      .box_y      (box_y_ff),
      .box_z      (box_z_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   pea_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   pea_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_job        (pop_job),
      .coulomb_factor (cf_ff),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .vdw_energy     (vdw_energy),
      .coulomb_energy (coulomb_energy),
      .range_error    (range_error)
   );

   assign rsp_tdata = {coulomb_energy, vdw_energy};
   assign rsp_tuser = range_error;

endmodule
